@@ rtl/core/bsme_pkg.sv @@
// Package for the stack machine execute core: opcodes, status codes, types.
// No dependencies.
package bsme_pkg;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int NUM_VARS = 26;

	typedef enum logic [4:0] {
		OP_FETCH = 5'd0, OP_STORE = 5'd1, OP_PUSH = 5'd2, OP_POP = 5'd3,
		OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7, OP_MOD = 5'd8,
		OP_LT = 5'd9, OP_GT = 5'd10, OP_GE = 5'd11, OP_LE = 5'd12, OP_EQ = 5'd13,
		OP_NE = 5'd14, OP_JZ = 5'd15, OP_JNZ = 5'd16, OP_JMP = 5'd17,
		OP_PRINT = 5'd18, OP_HALT = 5'd19
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_HALTED = 3'd1, ST_UNKNOWN = 3'd2, ST_OVERFLOW = 3'd3,
		ST_UNDERFLOW = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_READ2, S_DIV, S_WRITE, S_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic        want_rem;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;
endpackage

@@ rtl/core/bsme_if.sv @@
// Valid/ready channel carrying one word of type T.
// Depends on nothing.
interface bsme_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/bytecode_stack_machine_execute_core.sv @@
// Top level of the stack machine execute core.
// Depends on bsme_pkg, bsme_if, bsme_stack_mem, bsme_div.
//
// One instruction word in, one result word out. The operand stack sits in a
// synchronous memory with a registered read port. Each word passes through
// S_READ, S_WRITE and S_OUT; binary ops add S_READ2 for a second stack read,
// and div/mod also wait in S_DIV on the bit-serial divider. Variables are 26
// 32-bit registers reset to zero.
// A new word is taken once the previous result has been handed off, so any
// stall on the result side delays the next word.
module bytecode_stack_machine_execute_core #(
	parameter int STACK_DEPTH = bsme_pkg::STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bsme_if.sink   in_ch,
	bsme_if.source out_ch
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	bsme_pkg::state_t state_q, state_d;
	logic [SPW-1:0] sp_q;
	logic [31:0] vars_q [bsme_pkg::NUM_VARS];
	logic halted_q;
	logic [4:0] op_q, vi_q;
	logic [31:0] imm_q, b_q, r_q;
	logic [7:0] off_q;
	logic [31:0] rdata;
	logic [AW-1:0] raddr;
	logic we;
	logic [AW-1:0] waddr;
	logic [31:0] wdata;
	bsme_pkg::div_req_t dreq;
	logic ddone;
	logic [31:0] dres;
	logic [2:0] st_q;
	logic jt_q, pv_q;
	logic [7:0] jd_q;
	logic [31:0] pval_q;

	bsme_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);
	bsme_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .result(dres));

	logic [4:0] iop;
	logic grow, need1, need2, isbin, isdiv;
	assign iop = op_q;
	assign grow = iop == bsme_pkg::OP_FETCH || iop == bsme_pkg::OP_PUSH;
	assign isbin = iop >= bsme_pkg::OP_ADD && iop <= bsme_pkg::OP_NE;
	assign isdiv = iop == bsme_pkg::OP_DIV || iop == bsme_pkg::OP_MOD;
	assign need1 = iop == bsme_pkg::OP_STORE || iop == bsme_pkg::OP_POP
		|| iop == bsme_pkg::OP_JZ || iop == bsme_pkg::OP_JNZ || iop == bsme_pkg::OP_PRINT;
	assign need2 = isbin;

	logic [SPW-1:0] spm1, spm2;
	assign spm1 = sp_q - SPW'(1);
	assign spm2 = sp_q - SPW'(2);
	assign raddr = (state_q == bsme_pkg::S_READ) ? spm2[AW-1:0] : spm1[AW-1:0];

	logic [31:0] alu;
	logic lt_ab, lt_ba;
	assign lt_ab = $signed(rdata) < $signed(b_q);
	assign lt_ba = $signed(b_q) < $signed(rdata);
	always_comb begin
		unique case (iop)
			bsme_pkg::OP_ADD: alu = rdata + b_q;
			bsme_pkg::OP_SUB: alu = rdata - b_q;
			bsme_pkg::OP_LT: alu = {31'd0, lt_ab};
			bsme_pkg::OP_GT: alu = {31'd0, lt_ba};
			bsme_pkg::OP_GE: alu = {31'd0, !lt_ab};
			bsme_pkg::OP_LE: alu = {31'd0, !lt_ba};
			bsme_pkg::OP_EQ: alu = {31'd0, rdata == b_q};
			bsme_pkg::OP_NE: alu = {31'd0, rdata != b_q};
			default: alu = '0;
		endcase
	end

	logic [31:0] prod;
	assign prod = rdata * b_q;

	logic overflow, underflow;
	assign overflow = grow && (sp_q >= SPW'(STACK_DEPTH));
	assign underflow = (need1 && sp_q < SPW'(1)) || (need2 && sp_q < SPW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsme_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ch.ready = 1'b0;
		out_ch.valid = 1'b0;
		dreq = '{start: 1'b0, want_rem: iop == bsme_pkg::OP_MOD, a: rdata, b: b_q};
		unique case (state_q)
			bsme_pkg::S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = bsme_pkg::S_READ;
			end
			bsme_pkg::S_READ: begin
				if (halted_q || iop > bsme_pkg::OP_HALT || overflow || underflow
					|| !(need1 || need2)) state_d = bsme_pkg::S_WRITE;
				else if (need2) state_d = bsme_pkg::S_READ2;
				else state_d = bsme_pkg::S_WRITE;
			end
			bsme_pkg::S_READ2: begin
				if (isdiv) begin
					dreq.start = 1'b1;
					state_d = bsme_pkg::S_DIV;
				end else state_d = bsme_pkg::S_WRITE;
			end
			bsme_pkg::S_DIV: if (ddone) state_d = bsme_pkg::S_WRITE;
			bsme_pkg::S_WRITE: state_d = bsme_pkg::S_OUT;
			bsme_pkg::S_OUT: begin
				out_ch.valid = 1'b1;
				if (out_ch.ready) state_d = bsme_pkg::S_IDLE;
			end
			default: state_d = bsme_pkg::S_IDLE;
		endcase
	end

	// Write port and state update in S_WRITE.
	logic fault_q, bin_q;
	logic [31:0] pushv;
	always_comb begin
		we = 1'b0;
		waddr = sp_q[AW-1:0];
		wdata = r_q;
		pushv = (iop == bsme_pkg::OP_PUSH) ? imm_q :
			((vi_q < 5'(bsme_pkg::NUM_VARS)) ? vars_q[vi_q] : 32'd0);
		if (state_q == bsme_pkg::S_WRITE && !fault_q) begin
			if (grow) begin
				we = 1'b1;
				wdata = pushv;
			end else if (bin_q) begin
				we = 1'b1;
				waddr = spm2[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			halted_q <= 1'b0;
			for (int i = 0; i < bsme_pkg::NUM_VARS; i++) vars_q[i] <= '0;
			fault_q <= 1'b0;
			bin_q <= 1'b0;
		end else begin
			if (state_q == bsme_pkg::S_READ) begin
				fault_q <= halted_q || iop > bsme_pkg::OP_HALT || overflow || underflow;
				bin_q <= isbin;
				if (!halted_q && iop > bsme_pkg::OP_HALT) halted_q <= 1'b1;
				else if (!halted_q && iop == bsme_pkg::OP_HALT) halted_q <= 1'b1;
			end
			if (state_q == bsme_pkg::S_WRITE && !fault_q) begin
				if (grow) sp_q <= sp_q + SPW'(1);
				else if (bin_q) sp_q <= spm1;
				else if (need1) begin
					sp_q <= spm1;
					if (iop == bsme_pkg::OP_STORE && vi_q < 5'(bsme_pkg::NUM_VARS))
						vars_q[vi_q] <= b_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bsme_pkg::S_IDLE && in_ch.valid) begin
			op_q <= in_ch.data.mode;
			vi_q <= in_ch.data.var_index;
			imm_q <= in_ch.data.immediate;
			off_q <= in_ch.data.branch_offset;
		end
		if (state_q == bsme_pkg::S_READ) begin
			b_q <= rdata;
			if (halted_q) st_q <= bsme_pkg::ST_HALTED;
			else if (iop > bsme_pkg::OP_HALT) st_q <= bsme_pkg::ST_UNKNOWN;
			else if (overflow) st_q <= bsme_pkg::ST_OVERFLOW;
			else if (underflow) st_q <= bsme_pkg::ST_UNDERFLOW;
			else if (iop == bsme_pkg::OP_HALT) st_q <= bsme_pkg::ST_HALTED;
			else st_q <= bsme_pkg::ST_OK;
		end
		if (state_q == bsme_pkg::S_READ2) r_q <= (iop == bsme_pkg::OP_MUL) ? prod : alu;
		if (state_q == bsme_pkg::S_DIV && ddone) r_q <= dres;
		if (state_q == bsme_pkg::S_WRITE) begin
			jt_q <= 1'b0;
			jd_q <= '0;
			pv_q <= 1'b0;
			pval_q <= '0;
			if (!fault_q) begin
				if (iop == bsme_pkg::OP_JMP
					|| (iop == bsme_pkg::OP_JZ && b_q == 32'd0)
					|| (iop == bsme_pkg::OP_JNZ && b_q != 32'd0)) begin
					jt_q <= 1'b1;
					jd_q <= off_q;
				end
				if (iop == bsme_pkg::OP_PRINT) begin
					pv_q <= 1'b1;
					pval_q <= b_q;
				end
			end
		end
	end

	assign out_ch.data.status = st_q;
	assign out_ch.data.jump_taken = jt_q;
	assign out_ch.data.jump_distance = jd_q;
	assign out_ch.data.print_valid = pv_q;
	assign out_ch.data.print_value = pval_q;
endmodule

@@ rtl/core/bsme_div.sv @@
// Iterative signed divider, one quotient bit per cycle.
// Depends on bsme_pkg.
module bsme_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bsme_pkg::div_req_t req,
	output logic               done,
	output logic [31:0]        result
);
	logic [31:0] rem_q, quo_q, div_q;
	logic [5:0]  cnt_q;
	logic        busy_q, negq_q, negr_q, rem_sel_q, zero_q;
	logic [32:0] trial;
	logic [31:0] shr, mag_r, mag_q;

	assign shr = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shr} - {1'b0, div_q};
	assign mag_q = negq_q ? 32'd0 - quo_q : quo_q;
	assign mag_r = negr_q ? 32'd0 - rem_q : rem_q;
	assign result = zero_q ? 32'd0 : (rem_sel_q ? mag_r : mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.a[31] ? 32'd0 - req.a : req.a;
			div_q <= req.b[31] ? 32'd0 - req.b : req.b;
			rem_q <= '0;
			negq_q <= req.a[31] ^ req.b[31];
			negr_q <= req.a[31];
			rem_sel_q <= req.want_rem;
			zero_q <= (req.b == 32'd0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shr;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

@@ rtl/core/bsme_stack_mem.sv @@
// Operand stack memory: one write port, one registered read port.
// Depends on nothing.
module bsme_stack_mem #(
	parameter int DEPTH = 256,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sim/bsme_tb_pkg.sv @@
`timescale 1ns / 100ps
// Word layouts of the instruction and result channels for the execute core bench.
// Depends on bsme_pkg.
package bsme_tb_pkg;
	import bsme_pkg::*;

	typedef struct packed {
		logic [4:0]         mode;
		logic [4:0]         var_index;
		logic signed [31:0] immediate;
		logic signed [7:0]  branch_offset;
	} instr_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               jump_taken;
		logic signed [7:0]  jump_distance;
		logic               print_valid;
		logic signed [31:0] print_value;
	} result_t;
endpackage

@@ sim/bsme_checker.sv @@
`timescale 1ns / 100ps
// Watches both channels of the execute core, predicts each result and compares.
// Depends on bsme_pkg, bsme_tb_pkg, bsme_if.
module bsme_checker #(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	bsme_if      in_ch,
	bsme_if      out_ch,
	output int   fail_count,
	output int   pending,
	output int   checked
);
	import bsme_pkg::*;
	import bsme_tb_pkg::*;

	logic [31:0] stk [DEPTH];
	logic [31:0] vars [NUM_VARS];
	int          sp;
	logic        stopped;
	result_t     expected_q[$];

	function automatic logic [31:0] divide(logic [31:0] a, logic [31:0] b, bit rem);
		int sa, sb;
		sa = a;
		sb = b;
		if (b == 0)
			return 0;
		if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
			return rem ? 32'd0 : a;
		return rem ? sa % sb : sa / sb;
	endfunction

	function automatic result_t execute(instr_t w);
		result_t r;
		logic [31:0] a, b, v;
		int need, grow;
		r = '0;
		need = 0;
		grow = 0;
		if (stopped) begin
			r.status = ST_HALTED;
			return r;
		end
		if (w.mode > OP_HALT) begin
			r.status = ST_UNKNOWN;
			stopped = 1;
			return r;
		end
		case (w.mode)
			OP_FETCH, OP_PUSH: grow = 1;
			OP_STORE, OP_POP, OP_JZ, OP_JNZ, OP_PRINT: need = 1;
			OP_HALT, OP_JMP: need = 0;
			default: need = 2;
		endcase
		if (grow && sp >= DEPTH) begin
			r.status = ST_OVERFLOW;
		end else if (sp < need) begin
			r.status = ST_UNDERFLOW;
		end else begin
			case (w.mode)
				OP_FETCH: begin
					stk[sp] = (w.var_index < NUM_VARS) ? vars[w.var_index] : 32'd0;
					sp++;
				end
				OP_PUSH: begin
					stk[sp] = w.immediate;
					sp++;
				end
				OP_STORE: begin
					sp--;
					if (w.var_index < NUM_VARS)
						vars[w.var_index] = stk[sp];
				end
				OP_POP: sp--;
				OP_JZ, OP_JNZ: begin
					sp--;
					v = stk[sp];
					if ((w.mode == OP_JZ) == (v == 0)) begin
						r.jump_taken = 1;
						r.jump_distance = w.branch_offset;
					end
				end
				OP_JMP: begin
					r.jump_taken = 1;
					r.jump_distance = w.branch_offset;
				end
				OP_PRINT: begin
					sp--;
					r.print_valid = 1;
					r.print_value = stk[sp];
				end
				OP_HALT: begin
					stopped = 1;
					r.status = ST_HALTED;
				end
				default: begin
					b = stk[sp - 1];
					a = stk[sp - 2];
					sp -= 2;
					case (w.mode)
						OP_ADD: v = a + b;
						OP_SUB: v = a - b;
						OP_MUL: v = a * b;
						OP_DIV: v = divide(a, b, 0);
						OP_MOD: v = divide(a, b, 1);
						OP_LT:  v = $signed(a) < $signed(b);
						OP_GT:  v = $signed(a) > $signed(b);
						OP_GE:  v = $signed(a) >= $signed(b);
						OP_LE:  v = $signed(a) <= $signed(b);
						OP_EQ:  v = a == b;
						default: v = a != b;
					endcase
					stk[sp] = v;
					sp++;
				end
			endcase
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			sp = 0;
			stopped = 0;
			foreach (vars[i])
				vars[i] = 0;
			expected_q.delete();
			fail_count = 0;
			checked = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_q.push_back(execute(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				checked++;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: unexpected result word %h", $realtime, got);
				end else begin
					want = expected_q.pop_front();
					if (got.status !== want.status || got.jump_taken !== want.jump_taken
						|| got.jump_distance !== want.jump_distance
						|| got.print_valid !== want.print_valid
						|| got.print_value !== want.print_value) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t: mismatch st %0d/%0d jt %0d/%0d jd %0d/%0d pv %0d/%0d val %0d/%0d (exp/act)",
								$realtime, want.status, got.status, want.jump_taken, got.jump_taken,
								want.jump_distance, got.jump_distance, want.print_valid,
								got.print_valid, want.print_value, got.print_value);
					end
				end
			end
		end
	end
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Bench top: drives instruction words into the execute core with random gaps and stalls.
// Depends on bsme_pkg, bsme_tb_pkg, bsme_if, bsme_checker and the core.
module testbench;
	import bsme_pkg::*;
	import bsme_tb_pkg::*;

	localparam int DEPTH = 256;
	localparam int LIMIT = 600000;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending, checked;
	int   cycles = 0;
	int   depth = 0;
	int   sent = 0;
	bit   burst = 0;
	int   stall_left = 0;

	bsme_if #(.T(instr_t))  in_ch ();
	bsme_if #(.T(result_t)) out_ch ();

	bytecode_stack_machine_execute_core #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	bsme_checker #(.DEPTH(DEPTH)) chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 300 == 0)
			burst <= ($urandom_range(0, 3) == 0);
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (burst || p < 40)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ch.ready <= 0;
			stall_left <= stall_left - 1;
		end else begin
			out_ch.ready <= 1;
			stall_left <= gap_len();
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 0;
			4: return 1;
			5, 6: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(logic [4:0] mode, logic [4:0] vi = 0, logic [31:0] imm = 0,
		logic [7:0] off = 0);
		instr_t w;
		int g;
		w.mode = mode;
		w.var_index = vi;
		w.immediate = imm;
		w.branch_offset = off;
		case (mode)
			OP_FETCH, OP_PUSH: if (depth < DEPTH) depth++;
			OP_STORE, OP_POP, OP_JZ, OP_JNZ, OP_PRINT: if (depth >= 1) depth--;
			OP_JMP, OP_HALT: ;
			default: if (mode <= OP_NE && depth >= 2) depth--;
		endcase
		in_ch.valid <= 1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic random_word();
		int p;
		logic [4:0] vi;
		p = $urandom_range(0, 99);
		vi = ($urandom_range(0, 7) == 0) ? $urandom_range(26, 31) : $urandom_range(0, 25);
		if (depth > 200 && p < 38)
			p = 51;
		if (p < 30)
			send(OP_PUSH, $urandom, pick_value(), $urandom);
		else if (p < 38)
			send(OP_FETCH, vi, $urandom, $urandom);
		else if (p < 46)
			send(OP_STORE, vi);
		else if (p < 51)
			send(OP_POP);
		else if (p < 76)
			send(($urandom_range(0, 3) == 0) ? $urandom_range(OP_DIV, OP_MOD)
				: $urandom_range(OP_ADD, OP_NE));
		else if (p < 84)
			send($urandom_range(OP_JZ, OP_JNZ), 0, 0, $urandom);
		else if (p < 89)
			send(OP_JMP, 0, 0, $urandom);
		else if (p < 96)
			send(OP_PRINT);
		else
			send($urandom_range(0, OP_PRINT), $urandom, $urandom, $urandom);
	endtask

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(OP_POP);
		send(OP_JZ, 0, 0, 8'h80);
		send(OP_PUSH, 0, 32'h8000_0000);
		send(OP_ADD);
		send(OP_PUSH, 0, 32'hFFFF_FFFF);
		send(OP_DIV);
		send(OP_PUSH, 0, 32'h8000_0000);
		send(OP_PUSH, 0, 32'hFFFF_FFFF);
		send(OP_MOD);
		send(OP_PUSH, 0, 32'h7FFF_FFFF);
		send(OP_PUSH, 0, 0);
		send(OP_DIV);
		send(OP_PUSH, 0, -7);
		send(OP_PUSH, 0, 0);
		send(OP_MOD);
		send(OP_STORE, 25);
		send(OP_FETCH, 31);
		send(OP_STORE, 31);
		send(OP_FETCH, 25);
		send(OP_PRINT);
		send(OP_JZ, 0, 0, 8'h80);
		send(OP_JMP, 0, 0, 8'h7F);
		send(OP_FETCH, 0);
		send(OP_JNZ, 0, 0, 8'h55);
		send(OP_PRINT);

		repeat (250) random_word();

		// drain fully, then fill the stack to the top and push past it
		do @(posedge clk); while (pending != 0);
		repeat (60) @(posedge clk);
		while (depth < DEPTH) send(OP_PUSH, 0, pick_value());
		send(OP_PUSH, 0, $urandom);
		send(OP_FETCH, $urandom_range(0, 31));

		repeat (250) random_word();

		if ($urandom_range(0, 1))
			send(OP_HALT);
		else
			send($urandom_range(20, 31), $urandom, $urandom, $urandom);
		repeat (4) send($urandom, $urandom, $urandom, $urandom);
		in_ch.valid <= 0;

		do @(posedge clk); while (pending != 0);
		repeat (60) @(posedge clk);
		$display("%0d instruction words sent, %0d results checked", sent, checked);
		$display("covered underflow, a full stack, division corners and the halted state");
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
